FILE: src/mbp_pkg.sv
// package: shared types and constants for the msb-first bit packer
`default_nettype none
package mbp_pkg;

  localparam int WordBits = 64;
  localparam int LenW     = 7;
  localparam int CntW     = 6;

  localparam logic CmdAppend = 1'b0;
  localparam logic CmdFlush  = 1'b1;

  localparam logic [LenW-1:0] FullLen = LenW'(WordBits);

  typedef struct packed {
    logic                cmd;
    logic [WordBits-1:0] field_value;
    logic [LenW-1:0]     field_len;
  } item_t;

  typedef struct packed {
    logic [WordBits-1:0] packed_word;
    logic [LenW-1:0]     valid_bits;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

FILE: src/mbp_field_if.sv
// interface: field channel carrying append and flush commands
`default_nettype none
interface mbp_field_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [mbp_pkg::WordBits-1:0] field_value;
  logic [mbp_pkg::LenW-1:0]     field_len;

  modport source (output valid, output cmd, output field_value, output field_len,
                  input ready);
  modport sink   (input valid, input cmd, input field_value, input field_len,
                  output ready);
endinterface
`default_nettype wire

FILE: src/mbp_word_if.sv
// interface: word channel carrying packed output words
`default_nettype none
interface mbp_word_if;
  logic                         valid;
  logic                         ready;
  logic [mbp_pkg::WordBits-1:0] packed_word;
  logic [mbp_pkg::LenW-1:0]     valid_bits;
  logic                         last;

  modport source (output valid, output packed_word, output valid_bits, output last,
                  input ready);
  modport sink   (input valid, input packed_word, input valid_bits, input last,
                  output ready);
endinterface
`default_nettype wire

FILE: src/mbp_in_stage.sv
// module: input register for field channel transfers
`default_nettype none
module mbp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  mbp_field_if.sink          fields,
  output logic               item_valid,
  output mbp_pkg::item_t     item,
  input  wire logic          advance
);
  import mbp_pkg::*;

  assign fields.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (fields.valid && fields.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fields.valid && fields.ready) begin
      item.cmd         <= fields.cmd;
      item.field_value <= fields.field_value;
      item.field_len   <= fields.field_len;
    end
  end

endmodule
`default_nettype wire

FILE: src/mbp_pack_core.sv
// module: packing state and single-pass append/flush logic
`default_nettype none
module mbp_pack_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire mbp_pkg::item_t   item,
  input  wire logic             out_ready,
  output logic                  advance,
  output logic                  res_load,
  output mbp_pkg::result_t      res
);
  import mbp_pkg::*;

  logic [WordBits-1:0] partial_word;
  logic [WordBits-1:0] partial_word_next;
  logic [CntW-1:0]     bits_held;
  logic [CntW-1:0]     bits_held_next;

  logic [LenW-1:0]     len_sat;
  logic [WordBits-1:0] field_mask;
  logic [WordBits-1:0] value;
  logic [LenW-1:0]     total;
  logic [CntW-1:0]     fill_shift;
  logic [CntW-1:0]     rest;
  logic [CntW-1:0]     rest_shift;
  logic                res_valid;

  assign advance  = item_valid && out_ready;
  assign res_load = advance && res_valid;

  // overlong lengths count as a full word
  assign len_sat    = (item.field_len > FullLen) ? FullLen : item.field_len;
  assign field_mask = len_sat[CntW] ? '1
                    : ((WordBits'(1) << len_sat[CntW-1:0]) - WordBits'(1));
  assign value      = item.field_value & field_mask;
  assign total      = LenW'(bits_held) + len_sat;
  assign fill_shift = CntW'(FullLen - total);
  assign rest       = total[CntW-1:0];
  assign rest_shift = CntW'(FullLen - LenW'(rest));

  always_comb begin
    partial_word_next = partial_word;
    bits_held_next    = bits_held;
    res_valid         = 1'b0;
    res.packed_word   = partial_word;
    res.valid_bits    = LenW'(bits_held);
    res.last          = 1'b1;
    if (item.cmd == CmdFlush) begin
      res_valid         = (bits_held != '0);
      partial_word_next = '0;
      bits_held_next    = '0;
    end else if (len_sat != '0) begin
      if (!total[CntW]) begin
        partial_word_next = partial_word | (value << fill_shift);
        bits_held_next    = total[CntW-1:0];
      end else begin
        // word fills; leftover bits start the next word
        res_valid         = 1'b1;
        res.packed_word   = partial_word | (value >> rest);
        res.valid_bits    = FullLen;
        res.last          = 1'b0;
        partial_word_next = (rest == '0) ? '0 : (value << rest_shift);
        bits_held_next    = rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      bits_held    <= '0;
    end else if (advance) begin
      partial_word <= partial_word_next;
      bits_held    <= bits_held_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/mbp_out_stage.sv
// module: output register driving the word channel
`default_nettype none
module mbp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_load,
  input  wire mbp_pkg::result_t res,
  output logic                  out_ready,
  mbp_word_if.source            words
);
  import mbp_pkg::*;

  assign out_ready = !words.valid || words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      words.valid <= 1'b0;
    end else if (out_ready) begin
      words.valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && out_ready) begin
      words.packed_word <= res.packed_word;
      words.valid_bits  <= res.valid_bits;
      words.last        <= res.last;
    end
  end

endmodule
`default_nettype wire

FILE: src/msb_first_bit_packer_unit.sv
// top level: msb-first variable-length bit packer into 64-bit words
//
// fields channel: each transfer is one command. cmd append takes the low
// field_len bits (1..64, larger values act as 64, zero does nothing) of
// field_value and appends them after the bits already held, msb first.
// cmd flush emits the held partial word, zero padded at the low end, with
// last set, and empties the packer; a flush with nothing held emits nothing.
// words channel: packed_word holds the earliest bit in bit 63, valid_bits
// counts meaningful bits from the top (64 for a filled word).
// datapath: a field transfer loads the input register, the single-pass core
// merges it into the held bits, and the output register loads the word that
// then drives the words channel.
// throughput: one field transfer per cycle unless the receiver stalls, set
// by the single-pass shift and merge between the two registers; at most one
// word per field. the receiver may stall: the output register holds its word
// and the packer stops; fields.ready drops once the input register holds a
// field, so at most one more field is taken.
// reset (rst, synchronous) empties the packer and both registers.
`default_nettype none
module msb_first_bit_packer_unit (
  input  wire logic clk,
  input  wire logic rst,
  mbp_field_if.sink   fields,
  mbp_word_if.source  words
);
  import mbp_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    advance;
  logic    res_load;
  result_t res;
  logic    out_ready;

  mbp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .fields     (fields),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  mbp_pack_core u_pack_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .advance    (advance),
    .res_load   (res_load),
    .res        (res)
  );

  mbp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_ready (out_ready),
    .words     (words)
  );

endmodule
`default_nettype wire

FILE: src/mbp_checker.sv
// checker: port-level assertions for the bit packer, bound to the top level
`default_nettype none
module mbp_checker (
  input wire logic clk,
  input wire logic rst,
  mbp_field_if.sink  fields,
  mbp_word_if.source words
);
  import mbp_pkg::*;

  // a stalled word holds its payload
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    words.valid && !words.ready |=> words.valid && $stable(words.packed_word)
      && $stable(words.valid_bits) && $stable(words.last))
    else $error("stalled word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !words.valid)
    else $error("word valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    words.valid |-> words.valid_bits != '0 && words.valid_bits <= FullLen)
    else $error("valid_bits out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    words.valid && !words.last |-> words.valid_bits == FullLen)
    else $error("non-last word not full");

  // padding below the meaningful bits is zero
  a_zero_pad: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.last |-> (words.packed_word << words.valid_bits) == '0)
    else $error("nonzero padding in last word");

endmodule

bind msb_first_bit_packer_unit mbp_checker u_mbp_checker (
  .clk    (clk),
  .rst    (rst),
  .fields (fields),
  .words  (words)
);
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the msb-first bit packer: random field stream checked against a packing model
`timescale 1ns / 1ps
module tb_top;
  import mbp_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 8;
  localparam int RandomFields = 650;

  class bit_packer_tracker;
    logic [WordBits-1:0] partial_word;
    logic [LenW-1:0]     held_bits;
    result_t             pending_words[$];
    int                  mismatches;

    function new();
      partial_word = '0;
      held_bits    = '0;
      mismatches   = 0;
    endfunction

    // predict what one accepted field transfer produces
    function void take_field(item_t it);
      result_t             w;
      logic [WordBits-1:0] v;
      int                  len;
      int                  total;
      int                  rest;
      if (it.cmd == CmdFlush) begin
        if (held_bits != 0) begin
          w.packed_word = partial_word;
          w.valid_bits  = held_bits;
          w.last        = 1'b1;
          pending_words.push_back(w);
        end
        partial_word = '0;
        held_bits    = '0;
        return;
      end
      len = int'(it.field_len);
      if (len == 0) return;
      if (len > WordBits) len = WordBits;
      v = it.field_value;
      if (len < WordBits) v = v & ((64'd1 << len) - 64'd1);
      total = int'(held_bits) + len;
      if (total < WordBits) begin
        partial_word = partial_word | (v << (WordBits - total));
        held_bits    = LenW'(total);
      end else begin
        rest          = total - WordBits;
        w.packed_word = partial_word | (v >> rest);
        w.valid_bits  = FullLen;
        w.last        = 1'b0;
        pending_words.push_back(w);
        partial_word = (rest == 0) ? '0 : (v << (WordBits - rest));
        held_bits    = LenW'(rest);
      end
    endfunction

    function void match_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word expected none got %h/%0d/%0b",
                 $time, got.packed_word, got.valid_bits, got.last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got.packed_word !== want.packed_word) begin
        $display("%0t: packed_word expected %h got %h", $time, want.packed_word,
                 got.packed_word);
        mismatches++;
      end
      if (got.valid_bits !== want.valid_bits) begin
        $display("%0t: valid_bits expected %0d got %0d", $time, want.valid_bits,
                 got.valid_bits);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 37;
  int   stall_pct = 37;
  int   quiet_cycles = 0;

  bit_packer_tracker tracker = new();

  mbp_field_if fields_if();
  mbp_word_if  words_if();

  msb_first_bit_packer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .fields (fields_if),
    .words  (words_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    fields_if.valid       = 1'b0;
    fields_if.cmd         = CmdAppend;
    fields_if.field_value = '0;
    fields_if.field_len   = '0;
    words_if.ready        = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    words_if.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && words_if.valid && words_if.ready) begin
      got.packed_word = words_if.packed_word;
      got.valid_bits  = words_if.valid_bits;
      got.last        = words_if.last;
      tracker.match_word(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (fields_if.valid && fields_if.ready) || (words_if.valid && words_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic item_t make_field(logic cmd, logic [WordBits-1:0] value,
                                       logic [LenW-1:0] len);
    item_t it;
    it.cmd         = cmd;
    it.field_value = value;
    it.field_len   = len;
    return it;
  endfunction

  function automatic logic [WordBits-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // mostly well-formed appends of mixed lengths, some flushes and odd lengths
  function automatic item_t random_field();
    int                  pick;
    int                  len;
    logic [WordBits-1:0] v;
    pick = $urandom_range(99);
    case ($urandom_range(19))
      0:       v = '1;
      1:       v = '0;
      default: v = rand_word();
    endcase
    if (pick < 7) return make_field(CmdFlush, v, LenW'($urandom_range(127)));
    if (pick < 10) begin
      len = ($urandom_range(1) == 0) ? 0 : $urandom_range(127, WordBits + 1);
      return make_field(CmdAppend, v, LenW'(len));
    end
    if (pick < 50)      len = $urandom_range(8, 1);
    else if (pick < 75) len = $urandom_range(32, 9);
    else                len = $urandom_range(WordBits, 33);
    return make_field(CmdAppend, v, LenW'(len));
  endfunction

  // entered and left at a falling edge
  task automatic send_field(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      fields_if.valid       = 1'b0;
      fields_if.cmd         = 1'($urandom_range(1));
      fields_if.field_value = rand_word();
      fields_if.field_len   = LenW'($urandom_range(127));
      @(negedge clk);
    end
    fields_if.valid       = 1'b1;
    fields_if.cmd         = it.cmd;
    fields_if.field_value = it.field_value;
    fields_if.field_len   = it.field_len;
    do @(posedge clk); while (!fields_if.ready);
    tracker.take_field(it);
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_field(make_field(CmdAppend, '1, FullLen));
    send_field(make_field(CmdAppend, '0, FullLen));
    send_field(make_field(CmdFlush, '1, '1));
    send_field(make_field(CmdAppend, 64'd1, 7'd1));
    send_field(make_field(CmdAppend, '1, 7'd63));
    send_field(make_field(CmdAppend, 64'hA, 7'd0));
    send_field(make_field(CmdAppend, '1, 7'd127));
    send_field(make_field(CmdAppend, 64'h123, 7'd65));
    send_field(make_field(CmdAppend, 64'h5, 7'd3));
    send_field(make_field(CmdFlush, '0, '0));
    send_field(make_field(CmdFlush, '0, FullLen));
    send_field(make_field(CmdAppend, rand_word(), 7'd60));
    send_field(make_field(CmdAppend, rand_word(), 7'd10));
    send_field(make_field(CmdAppend, rand_word(), 7'd63));
    send_field(make_field(CmdAppend, rand_word(), 7'd11));
    send_field(make_field(CmdAppend, '1, 7'd1));
    send_field(make_field(CmdFlush, '1, 7'd1));
    send_field(make_field(CmdAppend, 64'hDEADBEEF_CAFEF00D, 7'd32));
    send_field(make_field(CmdAppend, '1, 7'd31));
    send_field(make_field(CmdFlush, rand_word(), 7'd0));
    send_field(make_field(CmdAppend, rand_word(), FullLen));

    for (int n = 0; n < RandomFields; n++) begin
      // a stretch with both sides running flat out
      if (n == 250) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (n == 400) begin
        idle_pct  = 37;
        stall_pct = 37;
      end
      send_field(random_field());
    end
    send_field(make_field(CmdFlush, '0, '0));
    fields_if.valid = 1'b0;

    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mbp_pkg.sv
src/mbp_field_if.sv
src/mbp_word_if.sv
src/mbp_in_stage.sv
src/mbp_pack_core.sv
src/mbp_out_stage.sv
src/msb_first_bit_packer_unit.sv
src/mbp_checker.sv
test/tb_top.sv
